// ===== src/stl_pkg.sv =====
// Shared types and constants for the source text tokenizer.
`timescale 1ns / 1ps

package stl_pkg;

	localparam int MAX_TEXT_BYTES = 65536;
	localparam int POS_W = 16;
	localparam int LEN_W = POS_W + 1;
	localparam int KIND_W = 5;
	localparam logic [POS_W-1:0] POS_CAP =
		POS_W'((MAX_TEXT_BYTES - 1 > 65535) ? 65535 : MAX_TEXT_BYTES - 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	typedef enum logic [KIND_W-1:0] {
		TK_IDENT  = 5'd0,
		TK_INT    = 5'd1,
		TK_SPACE  = 5'd2,
		TK_LPAREN = 5'd3,
		TK_RPAREN = 5'd4,
		TK_LBRACE = 5'd5,
		TK_RBRACE = 5'd6,
		TK_COMMA  = 5'd7,
		TK_COLON  = 5'd8,
		TK_SEMI   = 5'd9,
		TK_AMP    = 5'd10,
		TK_STAR   = 5'd11,
		TK_EQ     = 5'd12,
		TK_EQEQ   = 5'd13,
		TK_LT     = 5'd14,
		TK_LE     = 5'd15,
		TK_GT     = 5'd16,
		TK_GE     = 5'd17,
		TK_FN     = 5'd18,
		TK_ERROR  = 5'd19
	} kind_t;

	typedef enum logic [2:0] {
		PEND_NONE  = 3'd0,
		PEND_IDENT = 3'd1,
		PEND_INT   = 3'd2,
		PEND_SPACE = 3'd3,
		PEND_OP    = 3'd4
	} pend_t;

	typedef enum logic [1:0] {
		KW_NONE = 2'd0,
		KW_F    = 2'd1,
		KW_FN   = 2'd2
	} kw_t;

	typedef enum logic [1:0] {
		OP_EQ = 2'd0,
		OP_LT = 2'd1,
		OP_GT = 2'd2
	} op_t;

	typedef struct packed {
		pend_t            pend;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] start;
		kw_t              kw;
		op_t              op;
	} lex_state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  start;
		logic [LEN_W-1:0]  len;
		logic              last_of_run;
		logic              end_of_text;
	} token_t;

endpackage

// ===== src/stl_lex_step.sv =====
// One scanning step: classifies a byte against the pending token and forms up to two tokens.
`timescale 1ns / 1ps

module stl_lex_step (
	input  stl_pkg::lex_state_t st,
	input  logic [7:0]          text_byte,
	input  logic                last_byte,
	output stl_pkg::lex_state_t st_next,
	output logic [1:0]          tok_n,
	output stl_pkg::token_t     tok0,
	output stl_pkg::token_t     tok1
);
	import stl_pkg::*;

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {[8'h41:8'h5a], [8'h61:8'h7a]};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_white(input logic [7:0] c);
		return c inside {8'h20, 8'h0a, 8'h0d, 8'h09};
	endfunction

	function automatic logic is_identc(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == 8'h5f);
	endfunction

	function automatic logic is_oper(input logic [7:0] c);
		return c inside {8'h3d, 8'h3c, 8'h3e};
	endfunction

	function automatic op_t oper_code(input logic [7:0] c);
		op_t o;
		case (c)
			8'h3c:   o = OP_LT;
			8'h3e:   o = OP_GT;
			default: o = OP_EQ;
		endcase
		return o;
	endfunction

	// Single-character punctuation; anything else here is an error token.
	function automatic kind_t punct_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			8'h28:   k = TK_LPAREN;
			8'h29:   k = TK_RPAREN;
			8'h7b:   k = TK_LBRACE;
			8'h7d:   k = TK_RBRACE;
			8'h2c:   k = TK_COMMA;
			8'h3a:   k = TK_COLON;
			8'h3b:   k = TK_SEMI;
			8'h26:   k = TK_AMP;
			8'h2a:   k = TK_STAR;
			default: k = TK_ERROR;
		endcase
		return k;
	endfunction

	function automatic kind_t op_kind(input op_t o, input logic two);
		kind_t k;
		case (o)
			OP_EQ:   k = two ? TK_EQEQ : TK_EQ;
			OP_LT:   k = two ? TK_LE : TK_LT;
			default: k = two ? TK_GE : TK_GT;
		endcase
		return k;
	endfunction

	function automatic kind_t run_kind(input pend_t p, input kw_t kw);
		kind_t k;
		case (p)
			PEND_IDENT: k = (kw == KW_FN) ? TK_FN : TK_IDENT;
			PEND_INT:   k = TK_INT;
			default:    k = TK_SPACE;
		endcase
		return k;
	endfunction

	logic [POS_W-1:0] p;
	logic             fresh;
	logic             grows;
	lex_state_t       nx;
	// Close of the pending token, a token started and ended by this byte, and the end-of-text flush.
	logic             a_v, b_v, c_v;
	token_t           a, b, c;
	token_t           t0, t1;
	logic [1:0]       n;

	always_comb begin
		p = st.pos;
		nx = st;
		fresh = 1'b1;
		a_v = 1'b0;
		b_v = 1'b0;
		c_v = 1'b0;
		a = '0;
		b = '0;
		c = '0;
		a.start = st.start;
		b.start = p;
		b.len = LEN_W'(1);

		case (st.pend)
			PEND_IDENT: grows = is_identc(text_byte);
			PEND_INT:   grows = is_digit(text_byte);
			PEND_SPACE: grows = is_white(text_byte);
			default:    grows = 1'b0;
		endcase

		if (st.pend == PEND_OP) begin
			a_v = 1'b1;
			nx.pend = PEND_NONE;
			if (text_byte == 8'h3d) begin
				a.kind = op_kind(st.op, 1'b1);
				a.len = LEN_W'(2);
				fresh = 1'b0;
			end else begin
				a.kind = op_kind(st.op, 1'b0);
				a.len = LEN_W'(1);
			end
		end else if (st.pend != PEND_NONE) begin
			if (grows) begin
				fresh = 1'b0;
				if (st.pend == PEND_IDENT) begin
					nx.kw = (st.kw == KW_F && text_byte == 8'h6e) ? KW_FN : KW_NONE;
				end
			end else begin
				a_v = 1'b1;
				a.kind = run_kind(st.pend, st.kw);
				a.len = {1'b0, p} - {1'b0, st.start};
				nx.pend = PEND_NONE;
			end
		end

		if (fresh) begin
			if (is_alpha(text_byte)) begin
				nx.pend = PEND_IDENT;
				nx.start = p;
				nx.kw = (text_byte == 8'h66) ? KW_F : KW_NONE;
			end else if (is_digit(text_byte)) begin
				nx.pend = PEND_INT;
				nx.start = p;
			end else if (is_white(text_byte)) begin
				nx.pend = PEND_SPACE;
				nx.start = p;
			end else if (is_oper(text_byte)) begin
				nx.pend = PEND_OP;
				nx.op = oper_code(text_byte);
				nx.start = p;
			end else begin
				b_v = 1'b1;
				b.kind = punct_kind(text_byte);
			end
		end

		if (last_byte) begin
			c.start = nx.start;
			if (nx.pend == PEND_OP) begin
				c_v = 1'b1;
				c.kind = op_kind(nx.op, 1'b0);
				c.len = LEN_W'(1);
			end else if (nx.pend != PEND_NONE) begin
				c_v = 1'b1;
				c.kind = run_kind(nx.pend, nx.kw);
				c.len = {1'b0, p} - {1'b0, nx.start} + LEN_W'(1);
			end
			nx.pend = PEND_NONE;
			nx.pos = '0;
			nx.start = '0;
			nx.kw = KW_NONE;
			nx.op = OP_EQ;
		end else begin
			nx.pos = (p < POS_CAP) ? p + POS_W'(1) : POS_CAP;
		end

		// At most two of the three candidates are present; keep their order.
		n = 2'(a_v) + 2'(b_v) + 2'(c_v);
		t0 = a_v ? a : (b_v ? b : c);
		t1 = (a_v && b_v) ? b : c;
		if (n == 2'd1) begin
			t0.last_of_run = 1'b1;
			t0.end_of_text = last_byte;
		end else if (n == 2'd2) begin
			t1.last_of_run = 1'b1;
			t1.end_of_text = last_byte;
		end
	end

	assign st_next = nx;
	assign tok_n = n;
	assign tok0 = t0;
	assign tok1 = t1;

endmodule

// ===== src/stl_token_queue.sv =====
// Small token queue that takes up to two tokens a cycle and drives the output stream.
`timescale 1ns / 1ps

module stl_token_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      push_n,
	input  stl_pkg::token_t tok0,
	input  stl_pkg::token_t tok1,
	output logic            room,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [39:0]     m_axis_tdata,  // token_offset[15:0], token_length[32:16], zero pad
	output logic [5:0]      m_axis_tuser,  // token_kind[4:0], last_of_run[5]
	output logic            m_axis_tlast
);
	import stl_pkg::*;

	token_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;
	token_t            head;

	assign pop = m_axis_tvalid && m_axis_tready;
	assign room = count_q <= QCNT_W'(QUEUE_DEPTH - 2);
	assign head = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			entry_q[wr_q] <= tok0;
		end
		if (push_n == 2'd2) begin
			entry_q[wr_q + QPTR_W'(1)] <= tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + QPTR_W'(push_n);
			rd_q <= rd_q + QPTR_W'(pop);
			count_q <= count_q + QCNT_W'(push_n) - QCNT_W'(pop);
		end
	end

	assign m_axis_tvalid = count_q != '0;
	assign m_axis_tdata = {7'b0, head.len, head.start};
	assign m_axis_tuser = {head.last_of_run, head.kind};
	assign m_axis_tlast = head.end_of_text;

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> (QCNT_W + 1)'(count_q) + (QCNT_W + 1)'(push_n) <=
			(QCNT_W + 1)'(QUEUE_DEPTH))
		else $error("token queue overflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("token queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		QPTR_W'(count_q) == wr_q - rd_q)
		else $error("token queue pointers disagree with count");
`endif

endmodule

// ===== src/source_text_tokenizer_top.sv =====
// Top level of the source text tokenizer: input register, scanning state and output queue.
//
//  port group   dir  tdata                         tuser                    tlast
//  s_axis       in   text_byte[7:0]                -                        last_byte
//  m_axis       out  token_offset, token_length    token_kind, last_of_run  end_of_text
//
// One byte enters per cycle unless stalled; its tokens go from the input register into the queue.
// A byte that yields two tokens is absorbed by the four-entry queue, which sends one token at a time.
// The input stage stalls only when the queue cannot take two more tokens.
// Reset returns the scanner to offset zero with nothing pending and empties the queue.
`timescale 1ns / 1ps

module source_text_tokenizer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // text_byte[7:0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // token_offset[15:0], token_length[32:16], zero pad
	output logic [5:0]  m_axis_tuser,   // token_kind[4:0], last_of_run[5]
	output logic        m_axis_tlast
);
	import stl_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	lex_state_t state_q;
	lex_state_t state_next;
	logic [1:0] tok_n;
	token_t     tok0, tok1;
	logic       room;
	logic       commit;

	assign commit = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{pend: PEND_NONE, pos: '0, start: '0, kw: KW_NONE, op: OP_EQ};
		end else if (commit) begin
			state_q <= state_next;
		end
	end

	stl_lex_step u_step (
		.st        (state_q),
		.text_byte (byte_s1),
		.last_byte (last_s1),
		.st_next   (state_next),
		.tok_n     (tok_n),
		.tok0      (tok0),
		.tok1      (tok1)
	);

	stl_token_queue u_queue (
		.clk           (clk),
		.arst_n        (arst_n),
		.push_n        (commit ? tok_n : 2'd0),
		.tok0          (tok0),
		.tok1          (tok1),
		.room          (room),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

`ifndef SYNTH
	a_eot_resets: assert property (@(posedge clk) disable iff (!arst_n)
		commit && last_s1 |=> state_q.pend == PEND_NONE && state_q.pos == '0)
		else $error("scanner state not cleared after end of text");
	a_eot_emits: assert property (@(posedge clk) disable iff (!arst_n)
		commit && last_s1 |-> tok_n != 2'd0)
		else $error("end of text produced no token");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !commit |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("stalled input byte was lost or changed");
	a_start_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pend != PEND_NONE |-> state_q.start <= state_q.pos)
		else $error("pending token starts after current offset");
`endif

endmodule
